// ===== src/eeprom_wear_level_record_store_assert.svh =====
// ----------------------------------------------------------------------------
// eeprom wear-level record store assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef EEPROM_WEAR_LEVEL_RECORD_STORE_ASSERT_SVH
`define EEPROM_WEAR_LEVEL_RECORD_STORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define EWL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define EWL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ewl_pkg.sv =====
// ----------------------------------------------------------------------------
// ewl_pkg
// types and constants of the wear-leveled record store
// ----------------------------------------------------------------------------
package ewl_pkg;

    // default number of 8-byte slots
    localparam int SLOT_COUNT_DEF = 16;

    // stream widths
    localparam int REC_W    = 64;
    localparam int USED_W   = 4;
    localparam int IN_USER_W = 3;
    localparam int OUT_W    = 72;

    // slot contents after erase, and slot 0 after erase with boot marker
    localparam logic [REC_W-1:0] ERASED_WORD = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [REC_W-1:0] MARK_WORD   = 64'hFFFF_FFFF_FFFF_AA55;
    localparam logic [15:0]      MARK_BYTES  = 16'hAA55;

    // command codes
    typedef enum logic [1:0] {
        CMD_BOOT  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROBE,
        ST_EVAL,
        ST_HIGH_PROBE,
        ST_HIGH_EVAL,
        ST_ERASE,
        ST_WRITE,
        ST_BOOT_PROBE,
        ST_BOOT_EVAL,
        ST_DONE
    } state_t;

endpackage

// ===== src/eeprom_wear_level_record_store.sv =====
// ----------------------------------------------------------------------------
// eeprom_wear_level_record_store
// ring of 8-byte record slots with binary search for the newest record
// ----------------------------------------------------------------------------
// The store is one synchronous memory of SLOT_COUNT 64-bit slots with a
// registered read; a per-slot valid bit makes an unwritten slot read as erased
// (all bytes 0xFF), so erase clears every valid bit but slot 0's and
// writes the boot marker 0x55,0xAA into slot 0. Commands travel in s_axis_tuser
// (boot check, write record, read latest record); each command gives exactly
// one result transfer. A command is taken only while the sequencer is idle.
// Every search probe is a read issue and an evaluate step on the single
// memory port, and a search makes at most ceil(log2(SLOT_COUNT)) + 1 probes
// (4 or 5 for 16 slots) before it reads the high slot; a write adds a write
// step, and a write that wraps past the last slot adds an erase step and a
// second search; a boot check reads slot 0 and erases the store when force_erase
// is set or the marker is missing. The sequencer then returns to idle to take
// the next command. A finished result sits in the output register, so the next
// command can be accepted while it waits for m_axis_tready.
// ----------------------------------------------------------------------------
module eeprom_wear_level_record_store #(
    parameter int SLOT_COUNT = ewl_pkg::SLOT_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [ewl_pkg::REC_W-1:0]   s_axis_tdata,   // write_record[63:0]
    input  logic [ewl_pkg::IN_USER_W-1:0] s_axis_tuser, // cmd[1:0], force_erase[2]
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // read_record[63:0], found[64], boot_ok[65], slot_used[69:66], zero[71:70]
    output logic [ewl_pkg::OUT_W-1:0]   m_axis_tdata
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    // slot memory and per-slot valid bits
    logic [ewl_pkg::REC_W-1:0] mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]     valid_reg;
    logic [ewl_pkg::REC_W-1:0] rd_data_reg;
    logic                      rd_valid_reg;

    // memory access controls
    logic                      mem_we;
    logic                      mem_erase;
    logic [SLOT_W-1:0]         mem_waddr;
    logic [ewl_pkg::REC_W-1:0] mem_wdata;
    logic [SLOT_W-1:0]         mem_raddr;

    // sequencer and working registers
    ewl_pkg::state_t           state_reg, state_next;
    ewl_pkg::cmd_t             cmd_reg, cmd_next;
    logic                      force_reg, force_next;
    logic [ewl_pkg::REC_W-1:0] rec_reg, rec_next;
    logic [SLOT_W-1:0]         low_reg, low_next;
    logic [SLOT_W-1:0]         high_reg, high_next;
    logic                      cand_used_reg, cand_used_next;
    logic [ewl_pkg::REC_W-1:0] cand_data_reg, cand_data_next;
    logic [SLOT_W-1:0]         wslot_reg, wslot_next;

    // result registers
    logic [ewl_pkg::REC_W-1:0] res_rec_reg, res_rec_next;
    logic                      res_fnd_reg, res_fnd_next;
    logic                      res_ok_reg, res_ok_next;
    logic [ewl_pkg::USED_W-1:0] res_used_reg, res_used_next;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic [ewl_pkg::OUT_W-1:0] out_data_reg, out_data_next;

    // search helpers
    logic [SLOT_W-1:0]         mid;
    logic                      nonempty;
    logic                      loc_found;
    logic [SLOT_W-1:0]         loc_slot;
    logic [ewl_pkg::REC_W-1:0] loc_data;

    assign mid      = low_reg + ((high_reg - low_reg) >> 1);
    assign nonempty = rd_valid_reg && (rd_data_reg != ewl_pkg::ERASED_WORD);

    // final pick of the search: high slot if used, else the low probe
    always_comb
    begin
        if (nonempty)
        begin
            loc_found = 1'b1;
            loc_slot  = high_reg;
            loc_data  = rd_data_reg;
        end
        else
        begin
            loc_found = cand_used_reg;
            loc_slot  = low_reg;
            loc_data  = cand_data_reg;
        end
    end

    // slot memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg  <= mem[mem_raddr];
        rd_valid_reg <= valid_reg[mem_raddr];
    end

    // valid bits, erase clears all but slot 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (mem_erase)
        begin
            valid_reg <= SLOT_COUNT'(1);
        end
        else if (mem_we)
        begin
            valid_reg[mem_waddr] <= 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ewl_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        force_reg     <= force_next;
        rec_reg       <= rec_next;
        low_reg       <= low_next;
        high_reg      <= high_next;
        cand_used_reg <= cand_used_next;
        cand_data_reg <= cand_data_next;
        wslot_reg     <= wslot_next;
        res_rec_reg   <= res_rec_next;
        res_fnd_reg   <= res_fnd_next;
        res_ok_reg    <= res_ok_next;
        res_used_reg  <= res_used_next;
        out_data_reg  <= out_data_next;
    end

    // sequencer: next state, memory controls, results
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        force_next     = force_reg;
        rec_next       = rec_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        cand_used_next = cand_used_reg;
        cand_data_next = cand_data_reg;
        wslot_next     = wslot_reg;
        res_rec_next   = res_rec_reg;
        res_fnd_next   = res_fnd_reg;
        res_ok_next    = res_ok_reg;
        res_used_next  = res_used_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_erase      = 1'b0;
        mem_waddr      = wslot_reg;
        mem_wdata      = rec_reg;
        mem_raddr      = mid;
        s_axis_tready  = 1'b0;

        // result transfer retires the output register
        out_valid_next = out_valid_reg && !m_axis_tready;

        unique case (state_reg)
            ewl_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd_next      = ewl_pkg::cmd_t'(s_axis_tuser[1:0]);
                    force_next    = s_axis_tuser[2];
                    rec_next      = s_axis_tdata;
                    low_next      = '0;
                    high_next     = LAST_SLOT;
                    res_rec_next  = '0;
                    res_fnd_next  = 1'b0;
                    res_ok_next   = 1'b0;
                    res_used_next = '0;
                    unique case (s_axis_tuser[1:0]) inside
                        ewl_pkg::CMD_BOOT:  state_next = ewl_pkg::ST_BOOT_PROBE;
                        ewl_pkg::CMD_WRITE,
                        ewl_pkg::CMD_READ:  state_next = ewl_pkg::ST_PROBE;
                        default:            state_next = ewl_pkg::ST_DONE;
                    endcase
                end
            end

            ewl_pkg::ST_PROBE:
            begin
                mem_raddr  = mid;
                state_next = ewl_pkg::ST_EVAL;
            end

            // narrow the span, or hold the low probe and check the high slot
            ewl_pkg::ST_EVAL:
            begin
                if (mid == low_reg)
                begin
                    cand_used_next = nonempty;
                    cand_data_next = rd_data_reg;
                    state_next     = ewl_pkg::ST_HIGH_PROBE;
                end
                else
                begin
                    if (nonempty)
                    begin
                        low_next = mid;
                    end
                    else
                    begin
                        high_next = mid;
                    end
                    state_next = ewl_pkg::ST_PROBE;
                end
            end

            ewl_pkg::ST_HIGH_PROBE:
            begin
                mem_raddr  = high_reg;
                state_next = ewl_pkg::ST_HIGH_EVAL;
            end

            // search done: serve the read or pick the write slot
            ewl_pkg::ST_HIGH_EVAL:
            begin
                if (cmd_reg == ewl_pkg::CMD_READ)
                begin
                    res_fnd_next  = loc_found;
                    res_rec_next  = loc_found ? loc_data : '0;
                    res_used_next = loc_found ? ewl_pkg::USED_W'(loc_slot) : '0;
                    state_next    = ewl_pkg::ST_DONE;
                end
                else if (loc_slot == LAST_SLOT)
                begin
                    state_next = ewl_pkg::ST_ERASE;
                end
                else
                begin
                    wslot_next = loc_found ? SLOT_W'(loc_slot + 1'b1) : loc_slot;
                    state_next = ewl_pkg::ST_WRITE;
                end
            end

            // erase plus boot marker, then resume the command
            ewl_pkg::ST_ERASE:
            begin
                mem_we    = 1'b1;
                mem_erase = 1'b1;
                mem_waddr = '0;
                mem_wdata = ewl_pkg::MARK_WORD;
                low_next  = '0;
                high_next = LAST_SLOT;
                if (cmd_reg == ewl_pkg::CMD_BOOT)
                begin
                    state_next = ewl_pkg::ST_DONE;
                end
                else
                begin
                    state_next = ewl_pkg::ST_PROBE;
                end
            end

            ewl_pkg::ST_WRITE:
            begin
                mem_we        = 1'b1;
                mem_waddr     = wslot_reg;
                mem_wdata     = rec_reg;
                res_used_next = ewl_pkg::USED_W'(wslot_reg);
                state_next    = ewl_pkg::ST_DONE;
            end

            ewl_pkg::ST_BOOT_PROBE:
            begin
                mem_raddr  = '0;
                state_next = ewl_pkg::ST_BOOT_EVAL;
            end

            // marker check on bytes 0 and 1
            ewl_pkg::ST_BOOT_EVAL:
            begin
                if (force_reg || !rd_valid_reg ||
                    (rd_data_reg[15:0] != ewl_pkg::MARK_BYTES))
                begin
                    state_next = ewl_pkg::ST_ERASE;
                end
                else
                begin
                    res_ok_next = 1'b1;
                    state_next  = ewl_pkg::ST_DONE;
                end
            end

            // move the result into the output register once it is free
            ewl_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, res_used_reg, res_ok_reg, res_fnd_reg,
                                      res_rec_reg};
                    state_next     = ewl_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ewl_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== src/ewl_checker.sv =====
// ----------------------------------------------------------------------------
// ewl_checker
// port-level checks of the wear-leveled record store
// ----------------------------------------------------------------------------
`include "eeprom_wear_level_record_store_assert.svh"

module ewl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [ewl_pkg::OUT_W-1:0]     m_axis_tdata
);

    // a stalled result transfer holds its data
    `EWL_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // each command is worked on before the next is taken
    `EWL_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "command taken while busy")

    // found and boot_ok belong to different commands
    `EWL_ASSERT_IMP(a_flags_excl, m_axis_tvalid, !(m_axis_tdata[64] && m_axis_tdata[65]), "found and boot_ok both set")

    // a boot result with boot_ok set carries no record and no slot
    `EWL_ASSERT_IMP(a_boot_clean, m_axis_tvalid && m_axis_tdata[65], (m_axis_tdata[63:0] == '0) && (m_axis_tdata[71:66] == '0), "boot result carries data")

    // record data only comes with a located slot
    `EWL_ASSERT_IMP(a_rec_found, m_axis_tvalid && !m_axis_tdata[64], m_axis_tdata[63:0] == '0, "record data without found")

endmodule

bind eeprom_wear_level_record_store ewl_checker u_ewl_checker (.*);

// ===== sim/eeprom_wear_level_record_store_checker.sv =====
// ----------------------------------------------------------------------------
// eeprom_wear_level_record_store_checker
// watches both streams of the record store and checks every result transfer
// ----------------------------------------------------------------------------
// Each accepted command is run against a private image of the slot store.
// The expected result goes into a queue, and each accepted result transfer is
// compared field by field with the oldest entry in that queue. The module
// reports the number of mismatches and the number of results still owed.
// ----------------------------------------------------------------------------
module eeprom_wear_level_record_store_checker
    import ewl_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [REC_W-1:0]     s_axis_tdata,   // write_record[63:0]
    input  logic [IN_USER_W-1:0] s_axis_tuser,   // cmd[1:0], force_erase[2]
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // read_record[63:0], found[64], boot_ok[65], slot_used[69:66], zero[71:70]
    input  logic [OUT_W-1:0]     m_axis_tdata,
    output int                   error_count,
    output int                   results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    // bit positions in the result word
    localparam int FOUND_BIT = REC_W;
    localparam int BOOT_BIT  = REC_W + 1;
    localparam int SLOT_LSB  = REC_W + 2;
    localparam int PAD_LSB   = SLOT_LSB + USED_W;

    typedef struct packed {
        logic [REC_W-1:0]  rec;
        logic              found;
        logic              boot_ok;
        logic [USED_W-1:0] slot;
    } store_result_t;

    // image of the slot store, byte k of a slot at bits 8k+7..8k
    logic [REC_W-1:0] slot_image [SLOT_COUNT];
    store_result_t    owed_results [$];

    initial begin
        error_count = 0;
        results_due = 0;
    end

    function automatic bit slot_written(int idx);
        return slot_image[idx] != ERASED_WORD;
    endfunction

    function automatic void wipe_with_marker();
        foreach (slot_image[i])
            slot_image[i] = ERASED_WORD;
        slot_image[0] = MARK_WORD;
    endfunction

    // binary search for the newest written slot, returns the found flag
    function automatic bit find_newest(output int idx);
        int lo;
        int hi;
        int mid;
        lo  = 0;
        hi  = SLOT_COUNT - 1;
        mid = lo + (hi - lo) / 2;
        while (mid != lo) begin
            if (slot_written(mid))
                lo = mid;
            else
                hi = mid;
            mid = lo + (hi - lo) / 2;
        end
        if (slot_written(hi)) begin
            idx = hi;
            return 1'b1;
        end
        idx = mid;
        return slot_written(mid);
    endfunction

    // apply one command to the image and return the result it must produce
    function automatic store_result_t run_command(logic [1:0] cmd, logic force_erase,
                                                  logic [REC_W-1:0] rec);
        store_result_t r;
        int            idx;
        bit            hit;
        bit            wiped;
        r = '0;
        case (cmd)
            CMD_BOOT:
            begin
                wiped = 1'b0;
                if (force_erase) begin
                    wipe_with_marker();
                    wiped = 1'b1;
                end
                if (slot_image[0][15:0] != MARK_BYTES) begin
                    wipe_with_marker();
                    wiped = 1'b1;
                end
                r.boot_ok = !wiped;
            end
            CMD_WRITE:
            begin
                hit = find_newest(idx);
                // newest slot is the last one: wrap around after an erase
                if (idx == SLOT_COUNT - 1) begin
                    wipe_with_marker();
                    hit = find_newest(idx);
                end
                if (hit)
                    idx++;
                slot_image[idx] = rec;
                r.slot = idx[USED_W-1:0];
            end
            CMD_READ:
            begin
                if (find_newest(idx)) begin
                    r.rec   = slot_image[idx];
                    r.found = 1'b1;
                    r.slot  = idx[USED_W-1:0];
                end
            end
            default:
            begin
                // unused command leaves the store alone and returns zeros
            end
        endcase
        return r;
    endfunction

    task automatic note_mismatch(string field, logic [REC_W-1:0] want, logic [REC_W-1:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        error_count++;
    endtask

    // watch both streams: results first, then the command taken at this edge
    always @(posedge clk or negedge rst_n)
    begin : watch_streams
        store_result_t want;
        if (!rst_n) begin
            foreach (slot_image[i])
                slot_image[i] = ERASED_WORD;
            owed_results.delete();
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: result transfer with none owed, expected none, actual %h",
                             $time, m_axis_tdata);
                    error_count++;
                end
                else begin
                    want = owed_results.pop_front();
                    if (m_axis_tdata[REC_W-1:0] !== want.rec)
                        note_mismatch("read_record", want.rec, m_axis_tdata[REC_W-1:0]);
                    if (m_axis_tdata[FOUND_BIT] !== want.found)
                        note_mismatch("found", want.found, m_axis_tdata[FOUND_BIT]);
                    if (m_axis_tdata[BOOT_BIT] !== want.boot_ok)
                        note_mismatch("boot_ok", want.boot_ok, m_axis_tdata[BOOT_BIT]);
                    if (m_axis_tdata[SLOT_LSB +: USED_W] !== want.slot)
                        note_mismatch("slot_used", want.slot, m_axis_tdata[SLOT_LSB +: USED_W]);
                    if (m_axis_tdata[OUT_W-1:PAD_LSB] !== '0)
                        note_mismatch("padding", '0, m_axis_tdata[OUT_W-1:PAD_LSB]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                owed_results.push_back(run_command(s_axis_tuser[1:0], s_axis_tuser[2],
                                                   s_axis_tdata));
        end
        results_due = owed_results.size();
    end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the wear-leveled record store
// ----------------------------------------------------------------------------
// Drives a short directed sequence (empty store, boot marker handling, forced
// erase, all-ones and all-zeros records, unused command) followed by random
// commands weighted toward writes so the store fills and wraps many times.
// Both streams idle at random, with one stretch of steady traffic and one
// long result hold-off. The checker beside the block does all comparisons.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ewl_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int IDLE_PCT      = 26;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int HOLD_AT_ITEM  = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int STEADY_FIRST  = 700;
    localparam int STEADY_LAST   = 1000;
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 40;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [REC_W-1:0]     s_axis_tdata = '0;     // write_record[63:0]
    logic [IN_USER_W-1:0] s_axis_tuser = '0;     // cmd[1:0], force_erase[2]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // read_record[63:0], found[64], boot_ok[65], slot_used[69:66], zero[71:70]
    logic [OUT_W-1:0]     m_axis_tdata;

    int error_count;
    int results_due;
    int stall_cycles = 0;
    bit steady = 1'b0;
    bit hold_request = 1'b0;

    eeprom_wear_level_record_store #(
        .SLOT_COUNT(SLOT_COUNT_DEF)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    eeprom_wear_level_record_store_checker #(
        .SLOT_COUNT(SLOT_COUNT_DEF)
    ) store_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .error_count  (error_count),
        .results_due  (results_due)
    );

    // clock and reset
    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // result side: random back-pressure plus one long hold-off
    initial begin
        @(posedge clk iff rst_n);
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // end the run when no transfer happens for too long
    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // one command transfer, with an optional idle gap ahead of it
    task automatic send_command(input logic [1:0] cmd, input logic force_erase,
                                input logic [REC_W-1:0] rec);
        int gap;
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rec;
        s_axis_tuser  <= {force_erase, cmd};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // mostly random records, with erased-looking and all-zero ones mixed in
    function automatic logic [REC_W-1:0] random_record();
        logic [REC_W-1:0] rec;
        int               pick;
        rec  = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 8)
            rec = ERASED_WORD;
        else if (pick < 15)
            rec = '0;
        else if (pick < 25) begin
            // some bytes left at the erased value
            for (int k = 0; k < REC_W / 8; k++)
                if ($urandom_range(3) == 0)
                    rec[8*k +: 8] = 8'hFF;
        end
        return rec;
    endfunction

    // stimulus and verdict
    initial begin
        int          pick;
        logic [1:0]  cmd;
        logic        force_erase;
        @(posedge clk iff rst_n);

        // empty store: read finds nothing, write lands in slot 0 without marker
        send_command(CMD_READ, 1'b0, '0);
        send_command(CMD_WRITE, 1'b0, '0);
        send_command(CMD_READ, 1'b0, '0);
        // missing marker, valid marker, forced erase
        send_command(CMD_BOOT, 1'b0, '0);
        send_command(CMD_BOOT, 1'b0, ERASED_WORD);
        send_command(CMD_BOOT, 1'b1, '0);
        send_command(CMD_READ, 1'b0, '0);
        // all-ones record leaves its slot looking erased
        send_command(CMD_WRITE, 1'b0, ERASED_WORD);
        send_command(CMD_WRITE, 1'b0, '0);
        send_command(CMD_READ, 1'b0, '0);
        // unused command and force_erase on commands that ignore it
        send_command(CMD_UNUSED, 1'b1, ERASED_WORD);
        send_command(CMD_UNUSED, 1'b0, 64'h0123_4567_89AB_CDEF);
        send_command(CMD_WRITE, 1'b1, 64'h0123_4567_89AB_CDEF);
        send_command(CMD_READ, 1'b1, '0);
        send_command(CMD_BOOT, 1'b0, '0);
        send_command(CMD_WRITE, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
        send_command(CMD_WRITE, 1'b0, 64'h5555_5555_5555_5555);
        // fill toward the last slot and wrap
        for (int i = 0; i < 14; i++)
            send_command(CMD_WRITE, 1'b0, random_record());
        send_command(CMD_READ, 1'b0, '0);

        // random commands, weighted toward writes
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == HOLD_AT_ITEM)
                hold_request = 1'b1;
            steady = (i >= STEADY_FIRST) && (i < STEADY_LAST);
            pick = $urandom_range(99);
            if (pick < 55)
                cmd = CMD_WRITE;
            else if (pick < 80)
                cmd = CMD_READ;
            else if (pick < 92)
                cmd = CMD_BOOT;
            else
                cmd = CMD_UNUSED;
            force_erase = ($urandom_range(2) == 0);
            send_command(cmd, force_erase, random_record());
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        // drain outstanding results, then watch for strays
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== eeprom_wear_level_record_store.f =====
+incdir+src
src/ewl_pkg.sv
src/eeprom_wear_level_record_store.sv
src/ewl_checker.sv
sim/eeprom_wear_level_record_store_checker.sv
sim/testbench.sv
